// ===== hdl/ids_pkg.sv =====
// Shared types, constants and tables of the isotropic direction sampler.
package ids_pkg;

	localparam int FRAC_BITS = 22;

	typedef logic signed [23:0] q_t;
	typedef logic [31:0] ang_t;
	typedef logic signed [32:0] cw_t;

	localparam q_t ONE = 24'sd4194304;
	localparam logic [24:0] TURN = 25'd16777216;
	localparam logic signed [47:0] ONE_SQ = 48'sd17592186044416;
	localparam logic signed [49:0] RND_HALF = 50'sd2097152;

	// CORDIC start vector, gain already folded in, Q2.30
	localparam cw_t CORDIC_X0 = 33'sd652032874;
	localparam cw_t QUARTER = 33'sd1073741824;
	localparam cw_t HALF_TURN = 33'sd2147483648;
	localparam cw_t Q30_RND = 33'sd128;

	// atan(2^-i) in 2^-32 turns
	localparam logic [31:0] ATAN_TURNS [0:31] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	localparam int SQRT_STEPS = 23;
	localparam int SQRT_W = 46;
	localparam int SQRT_LAT = SQRT_STEPS + 1;

	typedef enum logic [2:0] {
		REG_COS_LO  = 3'd0,
		REG_COS_HI  = 3'd1,
		REG_PHI_LO  = 3'd2,
		REG_PHI_HI  = 3'd3,
		REG_OPTICAL = 3'd4
	} reg_idx_t;

endpackage

// ===== hdl/isotropic_direction_sampler.sv =====
// Top level: random unit direction in a cone segment with optional polarization.
//
//  channel  | direction | handshake          | beat
//  in       | sink      | in_valid/in_stall  | rand_polar, rand_azimuth, rand_rotation
//  out      | source    | out_valid/out_stall| dir_x/y/z, pol_x/y/z
//  cfg      | sink      | cfg_write          | cfg_index, cfg_data
//
// One beat per cycle while the output beat is not stalled. The pipe length is set by the CORDIC chain
// or the 23-step square root, whichever is longer; the shorter branch is padded to match.
// Reset loads the default cone (full sphere, optical off) and empties the pipe.
// The whole pipe holds while the output beat waits, so in_stall follows
// out_valid && out_stall; bubbles are not squeezed out.
module isotropic_direction_sampler #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [23:0]  rand_polar,
	input  logic [23:0]  rand_azimuth,
	input  logic [23:0]  rand_rotation,
	output logic         out_valid,
	input  logic         out_stall,
	output ids_pkg::q_t  dir_x,
	output ids_pkg::q_t  dir_y,
	output ids_pkg::q_t  dir_z,
	output ids_pkg::q_t  pol_x,
	output ids_pkg::q_t  pol_y,
	output ids_pkg::q_t  pol_z,
	input  logic         cfg_write,
	input  logic [2:0]   cfg_index,
	input  logic [24:0]  cfg_data
);
	import ids_pkg::*;

	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam int UNIT_LAT = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;
	localparam int CORDIC_PAD = UNIT_LAT - CORDIC_LAT;
	localparam int SQRT_PAD = UNIT_LAT - SQRT_LAT;

	function automatic logic signed [27:0] rnd_q(input logic signed [49:0] v);
		logic signed [49:0] t;
		t = v + RND_HALF;
		return 28'(t >>> FRAC_BITS);
	endfunction

	function automatic q_t clamp_q(input logic signed [27:0] v);
		if (v > 28'(ONE)) return ONE;
		if (v < -28'(ONE)) return -ONE;
		return v[23:0];
	endfunction

	// configuration
	q_t          cos_lo_q, cos_hi_q;
	logic [24:0] phi_lo_q, phi_hi_q;
	logic        optical_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_lo_q <= ONE;
			cos_hi_q <= -ONE;
			phi_lo_q <= '0;
			phi_hi_q <= TURN;
			optical_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COS_LO:  cos_lo_q <= cfg_data[23:0];
				REG_COS_HI:  cos_hi_q <= cfg_data[23:0];
				REG_PHI_LO:  phi_lo_q <= cfg_data;
				REG_PHI_HI:  phi_hi_q <= cfg_data;
				REG_OPTICAL: optical_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	q_t          cl, cu;
	logic [24:0] pl, pu;
	assign cl = (cos_lo_q > ONE) ? ONE : ((cos_lo_q < -ONE) ? -ONE : cos_lo_q);
	assign cu = (cos_hi_q > ONE) ? ONE : ((cos_hi_q < -ONE) ? -ONE : cos_hi_q);
	assign pl = (phi_lo_q > TURN) ? TURN : phi_lo_q;
	assign pu = (phi_hi_q > TURN) ? TURN : phi_hi_q;

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: linear map products
	logic signed [24:0] diff_c;
	logic signed [25:0] diff_p;
	logic signed [49:0] prod_c_s1;
	logic signed [50:0] prod_p_s1;
	logic [23:0]        rot_s1;
	logic               v_s1;

	assign diff_c = 25'(cl) - 25'(cu);
	assign diff_p = $signed({1'b0, pu}) - $signed({1'b0, pl});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_c_s1 <= $signed({1'b0, rand_polar}) * diff_c;
			prod_p_s1 <= $signed({1'b0, rand_azimuth}) * diff_p;
			rot_s1 <= rand_rotation;
		end
	end

	// stage 2: cos theta and phi
	logic signed [49:0] sh_c;
	logic signed [50:0] sh_p;
	logic signed [26:0] ct_wide;
	logic signed [25:0] phi_wide;
	q_t                 ct_s2;
	ang_t               phi_ang_s2;
	logic [23:0]        rot_s2;
	logic               v_s2;

	assign sh_c = prod_c_s1 >>> 24;
	assign sh_p = prod_p_s1 >>> 24;
	assign ct_wide = 27'(cl) - sh_c[26:0];
	assign phi_wide = $signed({1'b0, pl}) + sh_p[25:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ct_wide > 27'(ONE)) ct_s2 <= ONE;
			else if (ct_wide < -27'(ONE)) ct_s2 <= -ONE;
			else ct_s2 <= ct_wide[23:0];
			// a full turn wraps to zero
			phi_ang_s2 <= {phi_wide[23:0], 8'h00};
			rot_s2 <= rot_s1;
		end
	end

	// stage 3: one minus cos squared
	logic signed [47:0] ct_sq;
	logic [44:0]        rad_s3;
	q_t                 ct_s3;
	ang_t               phi_ang_s3;
	ang_t               rot_ang_s3;
	logic               v_s3;

	assign ct_sq = ct_s2 * ct_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= 45'(ONE_SQ - ct_sq);
			ct_s3 <= ct_s2;
			phi_ang_s3 <= phi_ang_s2;
			rot_ang_s3 <= {rot_s2, 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// trig and root units, padded to a common latency
	q_t          cp_u, sp_u, cr_u, sr_u;
	logic [22:0] st_u;
	logic [95:0] trig_a;
	logic [22:0] st_a;
	q_t          ct_a, cp_a, sp_a, cr_a, sr_a;
	logic        v_a;

	ids_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
		.clk(clk), .en(adv), .angle(phi_ang_s3), .cos_val(cp_u), .sin_val(sp_u)
	);

	ids_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_rot (
		.clk(clk), .en(adv), .angle(rot_ang_s3), .cos_val(cr_u), .sin_val(sr_u)
	);

	ids_isqrt u_isqrt (.clk(clk), .en(adv), .radicand(rad_s3), .root(st_u));

	ids_delay #(.WIDTH(96), .DEPTH(CORDIC_PAD)) u_trig_pad (
		.clk(clk), .arst_n(arst_n), .en(adv), .d({cp_u, sp_u, cr_u, sr_u}), .q(trig_a)
	);

	ids_delay #(.WIDTH(23), .DEPTH(SQRT_PAD)) u_sqrt_pad (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(st_u), .q(st_a)
	);

	ids_delay #(.WIDTH(24), .DEPTH(UNIT_LAT)) u_ct_line (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ct_s3), .q(ct_a)
	);

	ids_delay #(.WIDTH(1), .DEPTH(UNIT_LAT)) u_valid_line (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(v_s3), .q(v_a)
	);

	assign cp_a = $signed(trig_a[95:72]);
	assign sp_a = $signed(trig_a[71:48]);
	assign cr_a = $signed(trig_a[47:24]);
	assign sr_a = $signed(trig_a[23:0]);

	// stage 4: direction and reference vector products
	logic signed [47:0] m_stcp_s4, m_stsp_s4, m_ctcp_s4, m_ctsp_s4;
	q_t                 ct_s4, st_s4, cr_s4, sr_s4;
	logic               v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_stcp_s4 <= $signed({1'b0, st_a}) * cp_a;
			m_stsp_s4 <= $signed({1'b0, st_a}) * sp_a;
			m_ctcp_s4 <= ct_a * cp_a;
			m_ctsp_s4 <= ct_a * sp_a;
			ct_s4 <= ct_a;
			st_s4 <= $signed({1'b0, st_a});
			cr_s4 <= cr_a;
			sr_s4 <= sr_a;
		end
	end

	// stage 5: round to d and s
	q_t d0_s5, d1_s5, d2_s5, s0_s5, s1_s5, s2_s5, cr_s5, sr_s5;
	logic v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			d0_s5 <= 24'(-rnd_q(50'(m_stcp_s4)));
			d1_s5 <= 24'(-rnd_q(50'(m_stsp_s4)));
			d2_s5 <= -ct_s4;
			s0_s5 <= 24'(rnd_q(50'(m_ctcp_s4)));
			s1_s5 <= 24'(rnd_q(50'(m_ctsp_s4)));
			s2_s5 <= -st_s4;
			cr_s5 <= cr_s4;
			sr_s5 <= sr_s4;
		end
	end

	// stage 6: cross product terms
	logic signed [47:0] a0_s6, b0_s6, a1_s6, b1_s6, a2_s6, b2_s6;
	q_t d0_s6, d1_s6, d2_s6, s0_s6, s1_s6, s2_s6, cr_s6, sr_s6;
	logic v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			a0_s6 <= d1_s5 * s2_s5;
			b0_s6 <= d2_s5 * s1_s5;
			a1_s6 <= d2_s5 * s0_s5;
			b1_s6 <= d0_s5 * s2_s5;
			a2_s6 <= d0_s5 * s1_s5;
			b2_s6 <= d1_s5 * s0_s5;
			d0_s6 <= d0_s5;
			d1_s6 <= d1_s5;
			d2_s6 <= d2_s5;
			s0_s6 <= s0_s5;
			s1_s6 <= s1_s5;
			s2_s6 <= s2_s5;
			cr_s6 <= cr_s5;
			sr_s6 <= sr_s5;
		end
	end

	// stage 7: d x s
	logic signed [49:0] qd0, qd1, qd2;
	logic signed [24:0] q0_s7, q1_s7, q2_s7;
	q_t d0_s7, d1_s7, d2_s7, s0_s7, s1_s7, s2_s7, cr_s7, sr_s7;
	logic v_s7;

	assign qd0 = 50'(a0_s6) - 50'(b0_s6);
	assign qd1 = 50'(a1_s6) - 50'(b1_s6);
	assign qd2 = 50'(a2_s6) - 50'(b2_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s7 <= 25'(rnd_q(qd0));
			q1_s7 <= 25'(rnd_q(qd1));
			q2_s7 <= 25'(rnd_q(qd2));
			d0_s7 <= d0_s6;
			d1_s7 <= d1_s6;
			d2_s7 <= d2_s6;
			s0_s7 <= s0_s6;
			s1_s7 <= s1_s6;
			s2_s7 <= s2_s6;
			cr_s7 <= cr_s6;
			sr_s7 <= sr_s6;
		end
	end

	// stage 8: rotation products
	logic signed [47:0] cs0_s8, cs1_s8, cs2_s8;
	logic signed [48:0] sq0_s8, sq1_s8, sq2_s8;
	q_t d0_s8, d1_s8, d2_s8;
	logic v_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			cs0_s8 <= cr_s7 * s0_s7;
			cs1_s8 <= cr_s7 * s1_s7;
			cs2_s8 <= cr_s7 * s2_s7;
			sq0_s8 <= sr_s7 * q0_s7;
			sq1_s8 <= sr_s7 * q1_s7;
			sq2_s8 <= sr_s7 * q2_s7;
			d0_s8 <= d0_s7;
			d1_s8 <= d1_s7;
			d2_s8 <= d2_s7;
		end
	end

	// stage 9: output register
	q_t dir_x_s9, dir_y_s9, dir_z_s9, pol_x_s9, pol_y_s9, pol_z_s9;
	logic v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_x_s9 <= d0_s8;
			dir_y_s9 <= d1_s8;
			dir_z_s9 <= d2_s8;
			if (optical_q) begin
				pol_x_s9 <= clamp_q(rnd_q(50'(cs0_s8) + 50'(sq0_s8)));
				pol_y_s9 <= clamp_q(rnd_q(50'(cs1_s8) + 50'(sq1_s8)));
				pol_z_s9 <= clamp_q(rnd_q(50'(cs2_s8) + 50'(sq2_s8)));
			end else begin
				pol_x_s9 <= '0;
				pol_y_s9 <= '0;
				pol_z_s9 <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_a;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign out_valid = v_s9;
	assign dir_x = dir_x_s9;
	assign dir_y = dir_y_s9;
	assign dir_z = dir_z_s9;
	assign pol_x = pol_x_s9;
	assign pol_y = pol_y_s9;
	assign pol_z = pol_z_s9;
endmodule

// ===== hdl/ids_delay.sv =====
// Enabled shift line that aligns data between pipeline branches.
module ids_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] tap_s [0:DEPTH-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < DEPTH; i++) tap_s[i] <= '0;
				end else if (en) begin
					tap_s[0] <= d;
					for (int i = 1; i < DEPTH; i++) tap_s[i] <= tap_s[i-1];
				end
			end
			assign q = tap_s[DEPTH-1];
		end
	endgenerate
endmodule

// ===== hdl/ids_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ids_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [44:0] radicand,
	output logic [22:0] root
);
	import ids_pkg::*;

	logic [SQRT_W-1:0] v_s [0:SQRT_STEPS];
	logic [SQRT_W-1:0] r_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0] <= {1'b0, radicand};
			r_s[0] <= '0;
		end
	end

	genvar k;
	generate
		for (k = 0; k < SQRT_STEPS; k++) begin : g_step
			localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
			logic [SQRT_W-1:0] trial;
			assign trial = r_s[k] + BIT;
			always_ff @(posedge clk) begin
				if (en) begin
					if (v_s[k] >= trial) begin
						v_s[k+1] <= v_s[k] - trial;
						r_s[k+1] <= (r_s[k] >> 1) + BIT;
					end else begin
						v_s[k+1] <= v_s[k];
						r_s[k+1] <= r_s[k] >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = r_s[SQRT_STEPS][22:0];
endmodule

// ===== hdl/ids_cordic.sv =====
// Pipelined rotation CORDIC: cosine and sine of an angle in 2^-32 turns.
module ids_cordic #(
	parameter int STAGES = 24
) (
	input  logic         clk,
	input  logic         en,
	input  ids_pkg::ang_t angle,
	output ids_pkg::q_t   cos_val,
	output ids_pkg::q_t   sin_val
);
	import ids_pkg::*;

	cw_t  x_s [0:STAGES];
	cw_t  y_s [0:STAGES];
	cw_t  z_s [0:STAGES];
	logic flip_s [0:STAGES];
	cw_t  z_in;
	logic flip_in;

	function automatic q_t from_q30(input cw_t v);
		cw_t t;
		t = (v + Q30_RND) >>> (30 - FRAC_BITS);
		if (t > 33'(ONE)) return ONE;
		if (t < -33'(ONE)) return -ONE;
		return t[23:0];
	endfunction

	// fold the angle into the right half plane, negate the result later
	always_comb begin
		z_in = $signed({angle[31], angle});
		flip_in = 1'b0;
		if (z_in >= QUARTER) begin
			z_in = z_in - HALF_TURN;
			flip_in = 1'b1;
		end else if (z_in < -QUARTER) begin
			z_in = z_in + HALF_TURN;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_X0;
			y_s[0] <= '0;
			z_s[0] <= z_in;
			flip_s[0] <= flip_in;
		end
	end

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_iter
			localparam cw_t ATAN = $signed({1'b0, ATAN_TURNS[i]});
			always_ff @(posedge clk) begin
				if (en) begin
					flip_s[i+1] <= flip_s[i];
					if (z_s[i] >= 0) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - ATAN;
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + ATAN;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= from_q30(flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES]);
			sin_val <= from_q30(flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES]);
		end
	end
endmodule

// ===== hdl/ids_checker.sv =====
// Port-level checks of the sampler, bound to the top level.
module ids_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input ids_pkg::q_t dir_x,
	input ids_pkg::q_t dir_y,
	input ids_pkg::q_t dir_z,
	input ids_pkg::q_t pol_x,
	input ids_pkg::q_t pol_y,
	input ids_pkg::q_t pol_z
);
	import ids_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dir_x) && $stable(dir_y) && $stable(dir_z)
			&& $stable(pol_x) && $stable(pol_y) && $stable(pol_z))
		else $error("output beat changed while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (in_stall == (out_valid && out_stall)))
		else $error("input stall does not follow the output hold");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_x >= -ONE && dir_x <= ONE && dir_y >= -ONE && dir_y <= ONE
			&& dir_z >= -ONE && dir_z <= ONE && pol_x >= -ONE && pol_x <= ONE
			&& pol_y >= -ONE && pol_y <= ONE && pol_z >= -ONE && pol_z <= ONE)
		else $error("vector component out of range");
endmodule

bind isotropic_direction_sampler ids_checker u_ids_checker (.*);

// ===== bench/isotropic_direction_sampler_test.sv =====
// Self-checking bench for the direction sampler: directed cones, random streams, backpressure.
`timescale 1ns / 100ps

module isotropic_direction_sampler_test;
	import ids_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 45;
	localparam longint ONE_L = 64'sd4194304;
	localparam longint TURN_L = 64'sd16777216;

	typedef struct {
		q_t dx, dy, dz, px, py, pz;
	} sample_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] rand_polar, rand_azimuth, rand_rotation;
	logic        out_valid;
	logic        out_stall;
	q_t          dir_x, dir_y, dir_z, pol_x, pol_y, pol_z;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [24:0] cfg_data;

	// bench copy of the configuration registers
	logic [23:0] cone_cos_lo, cone_cos_hi;
	logic [24:0] cone_phi_lo, cone_phi_hi;
	logic        cone_optical;

	sample_t expected_samples[$];
	int      mismatches;
	int      checked;
	int      sent;
	int      idle_cycles;
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      hold_req;
	int      hold_left;

	isotropic_direction_sampler u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rand_polar(rand_polar), .rand_azimuth(rand_azimuth), .rand_rotation(rand_rotation),
		.out_valid(out_valid), .out_stall(out_stall),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.pol_x(pol_x), .pol_y(pol_y), .pol_z(pol_z),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_q(longint v);
		return (v + 64'sd2097152) >>> FRAC_BITS;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res;
		longint b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	// cos and sin of an angle in 2^-32 turns, rounded to Q1.22
	task automatic cos_sin(input logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'($signed(ang));
		x = longint'(CORDIC_X0);
		y = 0;
		flip = 0;
		if (z >= (64'sd1 <<< 30)) begin
			z = z - (64'sd1 <<< 31);
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z = z + (64'sd1 <<< 31);
			flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x = x - dy;
				y = y + dx;
				z = z - longint'({32'd0, ATAN_TURNS[i]});
			end else begin
				x = x + dy;
				y = y - dx;
				z = z + longint'({32'd0, ATAN_TURNS[i]});
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = sat((x + 128) >>> 8, -ONE_L, ONE_L);
		s = sat((y + 128) >>> 8, -ONE_L, ONE_L);
	endtask

	task automatic predict_sample(input logic [23:0] rp, ra, rr, output sample_t smp);
		longint cl, cu, pl, pu, ct, st, phi, cp, sp, cr, sr;
		longint d[3], s[3], q[3], p[3];
		logic [63:0] wide;
		cl = sat(longint'($signed(cone_cos_lo)), -ONE_L, ONE_L);
		cu = sat(longint'($signed(cone_cos_hi)), -ONE_L, ONE_L);
		pl = sat(longint'({39'd0, cone_phi_lo}), 0, TURN_L);
		pu = sat(longint'({39'd0, cone_phi_hi}), 0, TURN_L);
		ct = sat(cl - ((longint'({40'd0, rp}) * (cl - cu)) >>> 24), -ONE_L, ONE_L);
		st = int_sqrt(ONE_L * ONE_L - ct * ct);
		phi = pl + ((longint'({40'd0, ra}) * (pu - pl)) >>> 24);
		wide = phi << 8;
		cos_sin(wide[31:0], cp, sp);
		d[0] = -round_q(st * cp);
		d[1] = -round_q(st * sp);
		d[2] = -ct;
		p = '{0, 0, 0};
		if (cone_optical) begin
			s[0] = round_q(ct * cp);
			s[1] = round_q(ct * sp);
			s[2] = -st;
			q[0] = round_q(d[1] * s[2] - d[2] * s[1]);
			q[1] = round_q(d[2] * s[0] - d[0] * s[2]);
			q[2] = round_q(d[0] * s[1] - d[1] * s[0]);
			cos_sin({rr, 8'd0}, cr, sr);
			for (int k = 0; k < 3; k++)
				p[k] = sat(round_q(cr * s[k] + sr * q[k]), -ONE_L, ONE_L);
		end
		smp.dx = q_t'(d[0]);
		smp.dy = q_t'(d[1]);
		smp.dz = q_t'(d[2]);
		smp.px = q_t'(p[0]);
		smp.py = q_t'(p[1]);
		smp.pz = q_t'(p[2]);
	endtask

	// offer one beat, hold it until accepted, log its expected sample
	task automatic send_beat(input logic [23:0] rp, ra, rr);
		sample_t smp;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		rand_polar = rp;
		rand_azimuth = ra;
		rand_rotation = rr;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_sample(rp, ra, rr, smp);
		expected_samples.insert(expected_samples.size(), smp);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_beat(24'($urandom), 24'($urandom), 24'($urandom));
	endtask

	// wait for every expected sample, then let the pipe settle
	task automatic drain;
		in_valid = 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [24:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_COS_LO: cone_cos_lo = val[23:0];
			REG_COS_HI: cone_cos_hi = val[23:0];
			REG_PHI_LO: cone_phi_lo = val;
			REG_PHI_HI: cone_phi_hi = val;
			REG_OPTICAL: cone_optical = val[0];
			default: ;
		endcase
	endtask

	task automatic set_cone(input logic [24:0] cl, cu, pl, pu, input logic opt);
		write_reg(REG_COS_LO, cl);
		write_reg(REG_COS_HI, cu);
		write_reg(REG_PHI_LO, pl);
		write_reg(REG_PHI_HI, pu);
		write_reg(REG_OPTICAL, {24'd0, opt});
	endtask

	task automatic test_directed;
		// full sphere defaults, optical off: extremes of every fraction
		send_beat(24'h000000, 24'h000000, 24'h000000);
		send_beat(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_beat(24'h800000, 24'h400000, 24'hC00000);
		send_beat(24'h555555, 24'hAAAAAA, 24'h123456);
		drain();
		set_cone(25'h0400000, 25'h1C00000, 25'd0, 25'h1000000, 1'b1);
		send_beat(24'h000000, 24'h000000, 24'h000000);
		send_beat(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_beat(24'h800000, 24'h800000, 24'h400000);
		send_beat(24'h400000, 24'hC00000, 24'h800000);
		drain();
		// limits past the range saturate
		set_cone(25'h07FFFFF, 25'h0800000, 25'h1FFFFFF, 25'h1FFFFFF, 1'b1);
		send_beat(24'h000000, 24'h000000, 24'h200000);
		send_beat(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF);
		send_beat(24'h800000, 24'hFFFFFF, 24'h000001);
		drain();
		// reversed limits map backwards; azimuth of a full turn wraps
		set_cone(25'h1E00000, 25'h0300000, 25'h1000000, 25'h0400000, 1'b1);
		send_beat(24'h000000, 24'h000000, 24'h600000);
		send_beat(24'hFFFFFF, 24'hFFFFFF, 24'hE00000);
		send_beat(24'h7FFFFF, 24'h800000, 24'h3FFFFF);
		drain();
		// degenerate cone, rotation ignored with optical off
		set_cone(25'h0000000, 25'h0000000, 25'h0800000, 25'h0800000, 1'b0);
		send_beat(24'h000000, 24'h000000, 24'hFFFFFF);
		send_beat(24'hFFFFFF, 24'hFFFFFF, 24'h000000);
		send_beat(24'h123456, 24'h654321, 24'hABCDEF);
		drain();
	endtask

	function automatic logic [24:0] pick_cos;
		case ($urandom_range(0, 3))
			0: return 25'h0400000;
			1: return 25'h1C00000;
			2: return 25'($urandom);
			default: return {1'b0, 24'(longint'($urandom_range(0, 8388608)) - 64'sd4194304)};
		endcase
	endfunction

	function automatic logic [24:0] pick_phi;
		case ($urandom_range(0, 3))
			0: return 25'd0;
			1: return 25'h1000000;
			2: return 25'($urandom);
			default: return 25'($urandom_range(0, 16777216));
		endcase
	endfunction

	task automatic test_random_cones(input int n_sets, input int per_set);
		for (int k = 0; k < n_sets; k++) begin
			set_cone(pick_cos(), pick_cos(), pick_phi(), pick_phi(), $urandom_range(0, 3) != 0);
			send_random(per_set);
			drain();
		end
	endtask

	task automatic test_backpressure;
		set_cone(25'h0400000, 25'h1C00000, 25'd0, 25'h1000000, 1'b1);
		send_idle_pct = 0;
		hold_req = 1'b1;
		send_random(120);
		drain();
	endtask

	// receiver: random stall, long hold-off on request, check each output beat
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat at %0t", $realtime);
				end else begin
					sample_t e;
					e = expected_samples.pop_front();
					checked++;
					if (e.dx !== dir_x || e.dy !== dir_y || e.dz !== dir_z ||
							e.px !== pol_x || e.py !== pol_y || e.pz !== pol_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"beat %0d: exp dir %0d %0d %0d pol %0d %0d %0d,",
								" got dir %0d %0d %0d pol %0d %0d %0d"},
								checked, e.dx, e.dy, e.dz, e.px, e.py, e.pz,
								dir_x, dir_y, dir_z, pol_x, pol_y, pol_z);
					end
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				out_stall = $urandom_range(0, 99) < recv_idle_pct;
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rand_polar = '0;
		rand_azimuth = '0;
		rand_rotation = '0;
		cfg_write = 1'b0;
		cfg_index = REG_COS_LO;
		cfg_data = '0;
		cone_cos_lo = 24'h400000;
		cone_cos_hi = 24'hC00000;
		cone_phi_lo = 25'd0;
		cone_phi_hi = 25'h1000000;
		cone_optical = 1'b0;
		mismatches = 0;
		checked = 0;
		sent = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		send_idle_pct = 8;
		recv_idle_pct = 74;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_cones(4, 55);
		send_idle_pct = 74;
		recv_idle_pct = 8;
		test_random_cones(4, 55);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_cones(4, 55);
		recv_idle_pct = 30;
		test_backpressure();

		$display("covered %0d beats sent, %0d checked, over directed, saturated,", sent, checked);
		$display("reversed and random cones, idling on each side in turn and one long hold-off");
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== isotropic_direction_sampler.f =====
hdl/ids_pkg.sv
hdl/ids_delay.sv
hdl/ids_isqrt.sv
hdl/ids_cordic.sv
hdl/isotropic_direction_sampler.sv
hdl/ids_checker.sv
bench/isotropic_direction_sampler_test.sv
